// ===== hw/rtl/sha256_message_hasher_defines.svh =====
// Assertion macros shared by the SHA-256 message hasher RTL.
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside of reset.
`define SHAMH_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// Checks that a condition never holds outside of reset.
`define SHAMH_NEVER(name, clk, rst_n, cond) `SHAMH_ASSERT(name, clk, rst_n, !(cond))
`else
`define SHAMH_ASSERT(name, clk, rst_n, prop)
`define SHAMH_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/shamh_pkg.sv =====
// Types and constants shared by the SHA-256 message hasher modules.
package shamh_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_chain;
    typedef logic [15:0][31:0] t_block;

    // Command from the sequencer to the compression core.
    typedef struct packed {
        logic  push;
        t_word word;
        logic  start;
        logic  use_iv;
        logic  init_iv;
    } t_core_cmd;

    // Initial hash value; element 0 is word a.
    localparam t_chain IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Round constants.
    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== hw/rtl/shamh_core.sv =====
// SHA-256 compression core: block window, message schedule and one round per cycle.
module shamh_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shamh_pkg::t_core_cmd i_cmd,
    output logic                o_busy,
    output shamh_pkg::t_chain   o_chain
);

    // Round helper functions.
    function automatic shamh_pkg::t_word big_sig0(input shamh_pkg::t_word a);
        return {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    endfunction

    function automatic shamh_pkg::t_word big_sig1(input shamh_pkg::t_word e);
        return {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    endfunction

    function automatic shamh_pkg::t_word small_sig0(input shamh_pkg::t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic shamh_pkg::t_word small_sig1(input shamh_pkg::t_word y);
        return {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ {10'd0, y[31:10]};
    endfunction

    shamh_pkg::t_block r_w;       // block window, element 0 is the oldest word
    shamh_pkg::t_block n_w;
    shamh_pkg::t_chain r_v;       // working variables a..h
    shamh_pkg::t_chain n_v;
    shamh_pkg::t_chain r_h;       // chain value
    logic [5:0]        r_round;
    logic              r_busy;
    logic              r_final;

    shamh_pkg::t_word w_t1;
    shamh_pkg::t_word w_t2;
    shamh_pkg::t_word w_sched;
    shamh_pkg::t_word w_ch;
    shamh_pkg::t_word w_maj;
    logic             w_round_en;

    assign w_round_en = r_busy && !r_final;

    // One round of the compression function.
    always_comb begin
        w_ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1    = r_v[7] + big_sig1(r_v[4]) + w_ch + shamh_pkg::K_ROUND[r_round] + r_w[0];
        w_t2    = big_sig0(r_v[0]) + w_maj;
        w_sched = small_sig1(r_w[14]) + r_w[9] + small_sig0(r_w[1]) + r_w[0];
        n_v[0]  = w_t1 + w_t2;
        n_v[1]  = r_v[0];
        n_v[2]  = r_v[1];
        n_v[3]  = r_v[2];
        n_v[4]  = r_v[3] + w_t1;
        n_v[5]  = r_v[4];
        n_v[6]  = r_v[5];
        n_v[7]  = r_v[6];
    end

    // The window shifts on a pushed word or on each round's new schedule word.
    always_comb begin
        n_w = r_w;
        if (i_cmd.push) begin
            n_w = {i_cmd.word, r_w[15:1]};
        end else if (w_round_en) begin
            n_w = {w_sched, r_w[15:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    // Round sequencing, working variables and chain update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_final <= 1'b0;
            r_round <= '0;
            r_h     <= shamh_pkg::IV;
        end else begin
            if (i_cmd.init_iv) begin
                r_h <= shamh_pkg::IV;
            end
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_final <= 1'b0;
                r_round <= '0;
                if (i_cmd.use_iv) begin
                    r_v <= shamh_pkg::IV;
                    r_h <= shamh_pkg::IV;
                end else begin
                    r_v <= r_h;
                end
            end else if (w_round_en) begin
                r_v     <= n_v;
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_final <= 1'b1;
                end
            end else if (r_busy) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
                r_busy  <= 1'b0;
                r_final <= 1'b0;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_chain = r_h;

endmodule

// ===== hw/rtl/sha256_message_hasher.sv =====
// Sequencer and ports of the streaming SHA-256 message hasher.
//
// Message words enter one per cycle while the current 16-word block is
// filling; the word that completes a block starts a compression, during
// which the input is not ready. A compression runs one round per cycle
// through a single round unit: a start step, 64 rounds, a chain update
// and a step to resume. The last word adds padding at one word per cycle
// (up to 18 words, with one or two more compressions), a second 16-word
// block and compression in double mode, and then eight digest words, one
// per cycle as the output side takes them. The output register lets the
// next message start while the final digest word waits. The double_hash
// setting is sampled when the last word is taken.
`include "sha256_message_hasher_defines.svh"

module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FILL   = 3'd1;
    localparam logic [2:0] S_CSTART = 3'd2;
    localparam logic [2:0] S_CWAIT  = 3'd3;
    localparam logic [2:0] S_DBL    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;
    localparam logic [31:0] MARKER_WORD     = 32'h8000_0000;
    localparam logic [31:0] DIGEST_BITS     = 32'd256;
    localparam logic [3:0]  LEN_HI_SLOT     = 4'd14;
    localparam logic [3:0]  LAST_SLOT       = 4'd15;
    localparam logic [3:0]  DBL_MARK_SLOT   = 4'd8;
    localparam logic [2:0]  LAST_OUT_INDEX  = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_pos, n_pos;
    logic [63:0] r_bytes, n_bytes;
    logic        r_in_pad, n_in_pad;
    logic        r_marker, n_marker;
    logic        r_hi_done, n_hi_done;
    logic        r_len_done, n_len_done;
    logic        r_dbl, n_dbl;
    logic        r_second, n_second;
    logic        r_dbl_cfg;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_word, n_out_word;
    logic [2:0]  r_out_idx, n_out_idx;
    logic        r_out_last, n_out_last;

    shamh_pkg::t_core_cmd w_cmd;
    shamh_pkg::t_chain    w_chain;
    logic                 w_busy;
    logic                 w_accept;
    logic                 w_out_free;
    logic [2:0]           w_nv;
    logic [2:0]           w_add;
    logic [31:0]          w_merged;
    logic [63:0]          w_bits;

    shamh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_busy  (w_busy),
        .o_chain (w_chain)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_bits     = {r_bytes[60:0], 3'b000};

    // Byte count of the item: a count above four saturates to four, a non-final item is full.
    assign w_nv  = (i_valid_bytes > FULL_WORD_BYTES) ? FULL_WORD_BYTES : i_valid_bytes;
    assign w_add = i_last_word ? w_nv : FULL_WORD_BYTES;

    // Last word with padding marker after its valid bytes, when it has fewer than four.
    always_comb begin
        unique case (w_nv)
            3'd0:    w_merged = MARKER_WORD;
            3'd1:    w_merged = {i_data_word[31:24], 24'h80_0000};
            3'd2:    w_merged = {i_data_word[31:16], 16'h8000};
            3'd3:    w_merged = {i_data_word[31:8], 8'h80};
            default: w_merged = i_data_word;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_bytes     = r_bytes;
        n_in_pad    = r_in_pad;
        n_marker    = r_marker;
        n_hi_done   = r_hi_done;
        n_len_done  = r_len_done;
        n_dbl       = r_dbl;
        n_second    = r_second;
        n_oidx      = r_oidx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        w_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.push = 1'b1;
                    w_cmd.word = i_data_word;
                    n_pos      = r_pos + 4'd1;
                    n_bytes    = r_bytes + {61'd0, w_add};
                    if (i_last_word) begin
                        n_in_pad = 1'b1;
                        n_dbl    = r_dbl_cfg;
                        if (w_nv == FULL_WORD_BYTES) begin
                            n_marker = 1'b1;
                        end else begin
                            w_cmd.word = w_merged;
                        end
                    end
                    if (r_pos == LAST_SLOT) begin
                        n_state = S_CSTART;
                    end else if (i_last_word) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                w_cmd.push = 1'b1;
                n_pos      = r_pos + 4'd1;
                priority if (r_marker) begin
                    w_cmd.word = MARKER_WORD;
                    n_marker   = 1'b0;
                end else if (r_hi_done) begin
                    w_cmd.word = w_bits[31:0];
                    n_hi_done  = 1'b0;
                    n_len_done = 1'b1;
                end else if (r_pos == LEN_HI_SLOT) begin
                    w_cmd.word = w_bits[63:32];
                    n_hi_done  = 1'b1;
                end else begin
                    w_cmd.word = '0;
                end
                if (r_pos == LAST_SLOT) begin
                    n_state = S_CSTART;
                end
            end
            S_CSTART: begin
                w_cmd.start  = 1'b1;
                w_cmd.use_iv = r_second;
                n_state      = S_CWAIT;
            end
            S_CWAIT: begin
                if (!w_busy) begin
                    priority if (!r_in_pad) begin
                        n_state = S_IDLE;
                    end else if (!r_len_done) begin
                        n_state = S_FILL;
                    end else if (r_dbl && !r_second) begin
                        n_second = 1'b1;
                        n_state  = S_DBL;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_DBL: begin
                // Second block: first digest, marker, zeros, 256-bit length.
                w_cmd.push = 1'b1;
                n_pos      = r_pos + 4'd1;
                priority if (!r_pos[3]) begin
                    w_cmd.word = w_chain[r_pos[2:0]];
                end else if (r_pos == DBL_MARK_SLOT) begin
                    w_cmd.word = MARKER_WORD;
                end else if (r_pos == LAST_SLOT) begin
                    w_cmd.word = DIGEST_BITS;
                end else begin
                    w_cmd.word = '0;
                end
                if (r_pos == LAST_SLOT) begin
                    n_state = S_CSTART;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = w_chain[r_oidx];
                    n_out_idx   = r_oidx;
                    n_out_last  = (r_oidx == LAST_OUT_INDEX);
                    n_oidx      = r_oidx + 3'd1;
                    if (r_oidx == LAST_OUT_INDEX) begin
                        w_cmd.init_iv = 1'b1;
                        n_bytes       = '0;
                        n_in_pad      = 1'b0;
                        n_marker      = 1'b0;
                        n_hi_done     = 1'b0;
                        n_len_done    = 1'b0;
                        n_dbl         = 1'b0;
                        n_second      = 1'b0;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_bytes     <= '0;
            r_in_pad    <= 1'b0;
            r_marker    <= 1'b0;
            r_hi_done   <= 1'b0;
            r_len_done  <= 1'b0;
            r_dbl       <= 1'b0;
            r_second    <= 1'b0;
            r_dbl_cfg   <= 1'b0;
            r_oidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_bytes     <= n_bytes;
            r_in_pad    <= n_in_pad;
            r_marker    <= n_marker;
            r_hi_done   <= n_hi_done;
            r_len_done  <= n_len_done;
            r_dbl       <= n_dbl;
            r_second    <= n_second;
            r_oidx      <= n_oidx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_dbl_cfg <= i_cfg_wdata;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_digest_last = r_out_last;

    // A pushed word and a compression start never share a cycle.
    `SHAMH_NEVER(a_push_start, i_clk, i_rst_n, w_cmd.push && w_cmd.start)
    // A compression start makes the core busy in the next cycle.
    `SHAMH_ASSERT(a_start_busy, i_clk, i_rst_n, (r_state == S_CSTART) |=> w_busy)
    // The core only runs while the sequencer waits for it.
    `SHAMH_ASSERT(a_busy_wait, i_clk, i_rst_n, w_busy |-> (r_state == S_CWAIT))
    // The length words are only sent once the marker has gone out.
    `SHAMH_NEVER(a_len_order, i_clk, i_rst_n, r_marker && (r_hi_done || r_len_done))

endmodule

// ===== test/tb_sha256_message_hasher.sv =====
// Self-checking testbench for the streaming SHA-256 message hasher.
module tb_sha256_message_hasher;

    typedef logic [7:0][31:0]  t_chain;
    typedef logic [15:0][31:0] t_blk;

    // One digest word as it leaves the output channel.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    // One row of the directed stimulus; a typed digest is used when known is set.
    typedef struct packed {
        logic [31:0]  data;
        logic [2:0]   nbytes;
        logic         last;
        logic         known;
        logic [255:0] digest;
    } t_dir_row;

    localparam int N_DIR        = 22;
    localparam int SETTLE_CYCLES = 40;

    // Initial hash value; element 0 is word a.
    localparam t_chain HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Directed items: empty and "abc" messages with known digests, byte count
    // saturation, a short word inside a message, and a 14-word message that
    // needs two padding blocks.
    t_dir_row dir_rows [N_DIR] = '{
        '{32'hffffffff, 3'd0, 1'b1, 1'b1,
          256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855},
        '{32'h616263a5, 3'd3, 1'b1, 1'b1,
          256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad},
        '{32'h00000000, 3'd7, 1'b1, 1'b0, 256'h0},
        '{32'hffffffff, 3'd5, 1'b1, 1'b0, 256'h0},
        '{32'h12345678, 3'd1, 1'b0, 1'b0, 256'h0},
        '{32'h9abcdef0, 3'd2, 1'b1, 1'b0, 256'h0},
        '{32'hffffffff, 3'd4, 1'b0, 1'b0, 256'h0},
        '{32'h00000000, 3'd0, 1'b0, 1'b0, 256'h0},
        '{32'h80000000, 3'd7, 1'b0, 1'b0, 256'h0},
        '{32'h00000001, 3'd4, 1'b0, 1'b0, 256'h0},
        '{32'hdeadbeef, 3'd3, 1'b0, 1'b0, 256'h0},
        '{32'h7fffffff, 3'd4, 1'b0, 1'b0, 256'h0},
        '{32'hfffffffe, 3'd6, 1'b0, 1'b0, 256'h0},
        '{32'h01234567, 3'd4, 1'b0, 1'b0, 256'h0},
        '{32'h89abcdef, 3'd5, 1'b0, 1'b0, 256'h0},
        '{32'haaaaaaaa, 3'd4, 1'b0, 1'b0, 256'h0},
        '{32'h55555555, 3'd2, 1'b0, 1'b0, 256'h0},
        '{32'h0f0f0f0f, 3'd4, 1'b0, 1'b0, 256'h0},
        '{32'hf0f0f0f0, 3'd1, 1'b0, 1'b0, 256'h0},
        '{32'hc3c3c3c3, 3'd4, 1'b1, 1'b0, 256'h0},
        '{32'haaaaaaaa, 3'd6, 1'b1, 1'b0, 256'h0},
        '{32'h55555555, 3'd4, 1'b1, 1'b0, 256'h0}
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_data_word   = '0;
    logic [2:0]  i_valid_bytes = '0;
    logic        i_last_word   = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_digest_last;

    // Predicted hasher state and setting.
    t_chain      hash_state  = HASH_IV;
    t_blk        block_words = '0;
    logic [63:0] byte_total  = '0;
    int unsigned block_fill  = 0;
    bit          double_mode = 1'b0;

    t_digest_beat digest_due [$];
    int unsigned  error_count  = 0;
    int unsigned  words_sent   = 0;
    int unsigned  tx_idle_pct  = 0;
    int unsigned  rx_idle_pct  = 0;
    int unsigned  rx_hold_req  = 0;
    int unsigned  rx_hold_left = 0;

    sha256_message_hasher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_digest_last (o_digest_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // One 64-round compression of a 16-word block into a chaining value.
    function automatic t_chain sha_compress(input t_chain hv, input t_blk blk);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
        t_chain      res;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
        e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        res[0] = hv[0] + a; res[1] = hv[1] + b; res[2] = hv[2] + c; res[3] = hv[3] + d;
        res[4] = hv[4] + e; res[5] = hv[5] + f; res[6] = hv[6] + g; res[7] = hv[7] + h;
        return res;
    endfunction

    // Store a word in the block and compress once sixteen are in.
    function automatic void absorb_word(input logic [31:0] w);
        block_words[block_fill] = w;
        block_fill = (block_fill + 1) % 16;
        if (block_fill == 0) hash_state = sha_compress(hash_state, block_words);
    endfunction

    // Advances the predicted state by one item; returns the big-endian digest
    // when the item closes a message.
    function automatic logic [255:0] hash_message_word(input logic [31:0] d,
                                                       input logic [2:0] nb,
                                                       input logic lw);
        int unsigned  nbytes;
        logic [31:0]  keep;
        logic [63:0]  bits;
        t_chain       dg;
        t_blk         blk;
        logic [255:0] be;
        be = '0;
        if (!lw) begin
            byte_total += 4;
            absorb_word(d);
            return be;
        end
        nbytes = (nb > 3'd4) ? 4 : nb;
        byte_total += nbytes;
        if (nbytes == 4) begin
            absorb_word(d);
            absorb_word(32'h80000000);
        end else begin
            keep = (nbytes == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * nbytes));
            absorb_word((d & keep) | (32'h80 << (24 - 8 * nbytes)));
        end
        while (block_fill != 14) absorb_word(32'h0);
        bits = byte_total << 3;
        absorb_word(bits[63:32]);
        absorb_word(bits[31:0]);
        dg = hash_state;
        // Double mode hashes the 32-byte digest as a one-block message.
        if (double_mode) begin
            blk = '0;
            for (int i = 0; i < 8; i++) blk[i] = dg[i];
            blk[8]  = 32'h80000000;
            blk[15] = 32'd256;
            dg = sha_compress(HASH_IV, blk);
        end
        for (int i = 0; i < 8; i++) be[255 - 32 * i -: 32] = dg[i];
        hash_state = HASH_IV;
        byte_total = '0;
        block_fill = 0;
        return be;
    endfunction

    function automatic void queue_digest(input logic [255:0] be);
        t_digest_beat beat;
        for (int i = 0; i < 8; i++) begin
            beat.word  = be[255 - 32 * i -: 32];
            beat.index = 3'(i);
            beat.last  = (i == 7);
            digest_due = {digest_due, beat};
        end
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    // Compare one accepted digest word with the oldest expected one.
    function automatic void check_digest_word();
        t_digest_beat want;
        if (digest_due.size() == 0) begin
            note_error($sformatf("unexpected digest word %h index %0d",
                                 o_digest_word, o_word_index));
            return;
        end
        want = digest_due.pop_front();
        if (o_digest_word !== want.word)
            note_error($sformatf("digest_word exp %h got %h", want.word, o_digest_word));
        if (o_word_index !== want.index)
            note_error($sformatf("word_index exp %0d got %0d", want.index, o_word_index));
        if (o_digest_last !== want.last)
            note_error($sformatf("digest_last exp %0d got %0d", want.last, o_digest_last));
    endfunction

    // Output side: check each accepted word, then pick ready for the next cycle.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_digest_word();
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one item after a random gap and wait until it is taken.
    task automatic send_word(input logic [31:0] d, input logic [2:0] nb, input logic lw,
                             input logic use_typed, input logic [255:0] typed_digest);
        logic [255:0] dg;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_word   <= d;
        i_valid_bytes <= nb;
        i_last_word   <= lw;
        do @(posedge i_clk); while (!o_in_ready);
        dg = hash_message_word(d, nb, lw);
        if (lw) queue_digest(use_typed ? typed_digest : dg);
        words_sent++;
    endtask

    // Stop offering and wait until every expected digest word has come out.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (digest_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_double_hash(input bit v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        double_mode = v;
    endtask

    function automatic logic [31:0] rand_data();
        case ($urandom_range(9))
            0:       return 32'h00000000;
            1:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    // A message of random length; most words are full, a few carry odd byte counts.
    task automatic send_random_message();
        int unsigned body_len;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)      body_len = 0;
        else if (pick < 65) body_len = $urandom_range(15, 1);
        else if (pick < 90) body_len = $urandom_range(17, 13);
        else                body_len = $urandom_range(40, 18);
        for (int k = 0; k < body_len; k++)
            send_word(rand_data(), ($urandom_range(99) < 85) ? 3'd4 : 3'($urandom_range(7)),
                      1'b0, 1'b0, 256'h0);
        send_word(rand_data(), 3'($urandom_range(7)), 1'b1, 1'b0, 256'h0);
    endtask

    task automatic run_random_phase(input int unsigned target, input int unsigned hold,
                                    input bit mid_pause);
        int unsigned first_word;
        bit          paused;
        first_word = words_sent;
        paused     = 1'b0;
        if (hold != 0) rx_hold_req = hold;
        while (words_sent - first_word < target) begin
            if (mid_pause && !paused && (words_sent - first_word >= target / 2)) begin
                wait_idle();
                paused = 1'b1;
            end
            send_random_message();
        end
        wait_idle();
    endtask

    // Main sequence: reset, directed table, then random phases over both settings.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 30;
        rx_idle_pct = 57;
        write_double_hash(1'b0);
        for (int r = 0; r < N_DIR; r++)
            send_word(dir_rows[r].data, dir_rows[r].nbytes, dir_rows[r].last,
                      dir_rows[r].known, dir_rows[r].digest);
        wait_idle();

        // Long output stall at the start so the block backs up into its input.
        write_double_hash(1'b1);
        run_random_phase(60, 600, 1'b0);

        tx_idle_pct = 57;
        rx_idle_pct = 30;
        write_double_hash(1'b0);
        run_random_phase(60, 0, 1'b1);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_double_hash(1'b1);
        run_random_phase(60, 0, 1'b0);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sha256_message_hasher.f =====
+incdir+hw/rtl
hw/rtl/shamh_pkg.sv
hw/rtl/shamh_core.sv
hw/rtl/sha256_message_hasher.sv
test/tb_sha256_message_hasher.sv
